// File: rtl/lif_neuron_event_update_assert.svh
// assertion macros used by the checker file
`ifndef LIF_NEURON_EVENT_UPDATE_ASSERT_SVH
`define LIF_NEURON_EVENT_UPDATE_ASSERT_SVH
// a implies b on the same edge
`define LIF_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// a implies b on the next edge
`define LIF_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// File: rtl/lif_pkg.sv
// shared types and constants for the neuron event block
`default_nettype none
package lif_pkg;
	localparam logic [2:0] REG_DECAY = 3'd0;
	localparam logic [2:0] REG_INVCAP = 3'd1;
	localparam logic [2:0] REG_THRESH = 3'd2;
	localparam logic [2:0] REG_REST = 3'd3;
	localparam logic [2:0] REG_REFR = 3'd4;
	localparam logic [2:0] REG_BASE = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_READ, ST_LOAD, ST_XMUL, ST_EXP, ST_VMUL, ST_WMUL,
		ST_SUM, ST_WRITE
	} state_t;

	function automatic logic [23:0] exp_tab(input logic [4:0] b);
		logic [23:0] r;
		case (b)
			5'd0: r = 24'd16777215; 5'd1: r = 24'd16777214; 5'd2: r = 24'd16777212;
			5'd3: r = 24'd16777208; 5'd4: r = 24'd16777200; 5'd5: r = 24'd16777184;
			5'd6: r = 24'd16777152; 5'd7: r = 24'd16777088; 5'd8: r = 24'd16776960;
			5'd9: r = 24'd16776704; 5'd10: r = 24'd16776192; 5'd11: r = 24'd16775168;
			5'd12: r = 24'd16773120; 5'd13: r = 24'd16769026; 5'd14: r = 24'd16760840;
			5'd15: r = 24'd16744480; 5'd16: r = 24'd16711808; 5'd17: r = 24'd16646655;
			5'd18: r = 24'd16517109; 5'd19: r = 24'd16261035; 5'd20: r = 24'd15760736;
			5'd21: r = 24'd14805841; 5'd22: r = 24'd13066109; 5'd23: r = 24'd10175896;
			5'd24: r = 24'd6171993; 5'd25: r = 24'd2270549; 5'd26: r = 24'd307285;
			5'd27: r = 24'd5628; 5'd28: r = 24'd2;
			default: r = 24'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/lif_stream_if.sv
// valid/ready channel interfaces for events and spikes
`default_nettype none
interface lif_event_if;
	logic valid;
	logic ready;
	logic [9:0] cell_req;
	logic [31:0] arrival_tick;
	logic signed [31:0] weight;
	modport source(output valid, cell_req, arrival_tick, weight, input ready);
	modport sink(input valid, cell_req, arrival_tick, weight, output ready);
endinterface

interface lif_spike_if;
	logic valid;
	logic ready;
	logic [31:0] spike_cell;
	logic [31:0] spike_time;
	modport source(output valid, spike_cell, spike_time, input ready);
	modport sink(input valid, spike_cell, spike_time, output ready);
endinterface
`default_nettype wire

// File: rtl/lif_neuron_event_update.sv
// leaky integrate-and-fire cell array, one synaptic event at a time
// steps from event transfer to spike: read, elapsed*rate, up to 29 exp
//   steps, voltage and weight products, sum, write; all products share one multiplier
// events are taken one at a time, only in idle; a refractory drop or total decay cuts the pass short;
//   a held spike only stalls the write of the next firing event
// reset: config defaults, then a clearing pass over all CELLS entries zeroes both state memories
`default_nettype none
module lif_neuron_event_update
	import lif_pkg::*;
#(
	parameter int unsigned CELLS = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	lif_event_if.sink evt,
	lif_spike_if.source spk
);
	localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [23:0] decay_q, invcap_q;
	logic signed [31:0] thresh_q, rest_q;
	logic [15:0] refr_q;
	logic [31:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= 24'd16777; invcap_q <= 24'd65536; thresh_q <= 32'sd1310720;
			rest_q <= '0; refr_q <= 16'd200; base_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY: decay_q <= cfg_data[23:0];
				REG_INVCAP: invcap_q <= cfg_data[23:0];
				REG_THRESH: thresh_q <= cfg_data;
				REG_REST: rest_q <= cfg_data;
				REG_REFR: refr_q <= cfg_data[15:0];
				REG_BASE: base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] volt_mem [CELLS];
	logic [31:0] time_mem [CELLS];
	logic [31:0] volt_rd_q, time_rd_q;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] volt_wd, time_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			volt_mem[mem_addr] <= volt_wd;
			time_mem[mem_addr] <= time_wd;
		end
		volt_rd_q <= volt_mem[mem_addr];
		time_rd_q <= time_mem[mem_addr];
	end

	state_t state_q, state_d;
	logic [AW:0] clr_q;
	logic [4:0] bit_q;
	logic [AW-1:0] cell_q;
	logic [31:0] t_q, lu_q;
	logic signed [31:0] w_q, v_q;
	logic [55:0] x_q;
	logic [24:0] f_q;
	logic signed [39:0] inc_q;
	logic fire_q;
	logic out_valid_q;
	logic [31:0] out_cell_q, out_time_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic [1:0] xph_q;
	logic [31:0] elapsed;
	logic wr_go;

	lif_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	logic [31:0] req_ext;
	logic evt_ok;
	assign req_ext = {22'd0, evt.cell_req};
	assign evt_ok = (req_ext < 32'(CELLS));
	assign evt.ready = (state_q == ST_IDLE);
	assign elapsed = t_q - lu_q;
	// a firing event waits in write until the held spike leaves
	assign wr_go = !fire_q || !out_valid_q || spk.ready;

	// x = elapsed * rate in two 16-bit halves of elapsed
	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			ST_XMUL: begin
				ma = (xph_q == 2'd0) ? {17'd0, elapsed[15:0]} : {17'd0, elapsed[31:16]};
				mb = {9'd0, decay_q};
			end
			ST_EXP: begin
				ma = {8'd0, f_q};
				mb = {9'd0, exp_tab(bit_q)};
			end
			ST_VMUL: begin ma = {v_q[31], v_q}; mb = {8'd0, f_q}; end
			ST_WMUL: begin ma = {w_q[31], w_q}; mb = {9'd0, invcap_q}; end
			default: ;
		endcase
	end

	logic signed [65:0] vr, wr;
	assign vr = (mp + 66'sd8388608) >>> 24;
	assign wr = (mp + 66'sd32768) >>> 16;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == (AW+1)'(CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (evt.valid && evt.ready && evt_ok) state_d = ST_READ;
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = (t_q < time_rd_q) ? ST_IDLE : ST_XMUL;
			ST_XMUL: if (xph_q == 2'd3) state_d = ST_EXP;
			ST_EXP: if ((xph_q[0] && bit_q == 5'd28) || x_q[55:29] != '0) state_d = ST_VMUL;
			ST_VMUL: if (xph_q == 2'd1) state_d = ST_WMUL;
			ST_WMUL: if (xph_q == 2'd1) state_d = ST_SUM;
			ST_SUM: state_d = ST_WRITE;
			ST_WRITE: if (wr_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic signed [40:0] sum_c;
	assign sum_c = 41'(v_q) + 41'(inc_q);
	logic signed [31:0] vsat;
	always_comb begin
		if (sum_c > 41'sd2147483647) vsat = 32'sh7fffffff;
		else if (sum_c < -41'sd2147483648) vsat = 32'sh80000000;
		else vsat = sum_c[31:0];
	end
	logic [32:0] nt;
	assign nt = {1'b0, t_q} + {17'd0, refr_q};

	always_comb begin
		mem_we = 1'b0; mem_addr = cell_q; volt_wd = vsat; time_wd = t_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1; mem_addr = clr_q[AW-1:0]; volt_wd = '0; time_wd = '0;
			end
			ST_IDLE: mem_addr = req_ext[AW-1:0];
			ST_WRITE: begin
				mem_we = wr_go;
				if (fire_q) begin
					volt_wd = rest_q;
					time_wd = nt[32] ? 32'hffffffff : nt[31:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; out_valid_q <= 1'b0;
			bit_q <= '0; xph_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_WRITE && fire_q && wr_go) out_valid_q <= 1'b1;
			else if (spk.valid && spk.ready) out_valid_q <= 1'b0;
			if (state_q == ST_XMUL || state_q == ST_EXP || state_q == ST_VMUL ||
					state_q == ST_WMUL)
				xph_q <= (state_d != state_q) ? 2'd0 : xph_q + 2'd1;
			if (state_q == ST_EXP) begin
				if (xph_q[0]) bit_q <= bit_q + 5'd1;
			end else begin
				bit_q <= '0;
			end
		end
	end

	// each exp step issues on the even phase, its product lands on the odd phase
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cell_q <= req_ext[AW-1:0]; t_q <= evt.arrival_tick; w_q <= evt.weight;
			end
			ST_LOAD: begin lu_q <= time_rd_q; v_q <= volt_rd_q; end
			ST_XMUL: begin
				// phase 1: low product ready while the high half issues
				if (xph_q == 2'd1) x_q <= 56'(mp[39:0]);
				if (xph_q == 2'd3) begin
					x_q <= x_q + {mp[39:0], 16'd0};
					f_q <= 25'd16777216;
				end
			end
			ST_EXP: begin
				if (x_q[55:29] != '0) f_q <= '0;
				else if (xph_q[0] && x_q[bit_q]) f_q <= vr[24:0];
			end
			ST_VMUL: if (xph_q == 2'd1) v_q <= vr[31:0];
			ST_WMUL: if (xph_q == 2'd1) inc_q <= wr[39:0];
			ST_SUM: fire_q <= (vsat >= thresh_q);
			ST_WRITE: if (fire_q && wr_go) begin
				out_cell_q <= base_q + 32'(cell_q); out_time_q <= t_q;
			end
			default: ;
		endcase
	end

	assign spk.valid = out_valid_q;
	assign spk.spike_cell = out_cell_q;
	assign spk.spike_time = out_time_q;
endmodule
`default_nettype wire

// File: rtl/lif_mul.sv
// shared signed 33x33 multiplier with registered product
`default_nettype none
module lif_mul
	import lif_pkg::*;
(
	input wire logic clk,
	input wire logic signed [32:0] a,
	input wire logic signed [32:0] b,
	output logic signed [65:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

// File: rtl/lif_checker.sv
// port-level checks for the neuron event block
`default_nettype none
`include "lif_neuron_event_update_assert.svh"
module lif_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [31:0] out_time
);
	`LIF_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	`LIF_ASSERT_NEXT(a_no_instant_spike, clk, arst_n, in_valid && in_ready, !$rose(out_valid))
	`LIF_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_time))
endmodule

bind lif_neuron_event_update lif_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(evt.valid), .in_ready(evt.ready),
	.out_valid(spk.valid), .out_ready(spk.ready), .out_time(spk.spike_time)
);
`default_nettype wire
